// File: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/mre_pkg.sv
// Shared types, constants and opcodes for the instruction executor.
package mre_pkg;

  localparam int DATA_WORDS = 128;
  localparam int DADDR_W    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int REGS       = 32;
  localparam int RIDX_W     = 5;
  localparam int XLEN       = 32;
  localparam int PC_W       = 16;
  localparam int IMM_W      = 16;

  typedef enum logic [5:0] {
    OP_ADDI = 6'd1,
    OP_ADD  = 6'd2,
    OP_SLT  = 6'd3,
    OP_BNE  = 6'd4,
    OP_BEQ  = 6'd5,
    OP_LW   = 6'd6,
    OP_SW   = 6'd7,
    OP_SRL  = 6'd8,
    OP_SLL  = 6'd9,
    OP_ANDI = 6'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_OP   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  // Outcome of executing one running instruction.
  typedef struct packed {
    logic               wr_en;     // nonzero register written
    logic [RIDX_W-1:0]  wr_idx;
    logic [XLEN-1:0]    wr_val;    // not meaningful for loads
    logic               is_load;
    logic               mem_we;
    logic               addr_ok;
    logic [DADDR_W-1:0] mem_addr;
    status_t            status;
    logic [PC_W-1:0]    next_pc;
  } exec_t;

endpackage

// File: rtl/core/mini_risc_instruction_executor.sv
// Top level: three-stage pipelined MIPS-like executor, one instruction per item.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata[31:0] instruction word
//  m_*     | out | m_tvalid / m_tready  | m_tdata[87:0] results, m_tuser halted flag
//
// One item per cycle sustained while the pipeline is not stalled; an accepted item flows
// from the accept edge through the register read -> execute stage -> writeback stage -> output register.
// Register file and data memory have registered reads; results still in flight are
// forwarded from the writeback stage and a last-write register, so no bubbles.
// rst (synchronous) clears pc, step count, halt flag, pipeline valids and the
// per-entry valid bits of both memories, so every entry reads zero after reset.
// The whole pipeline advances together; it stalls only while the output register
// is full and m_tready is low, and s_tready drops for exactly those cycles.
module mini_risc_instruction_executor
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] instruction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [15:0] next_pc, [17:16] status, [18] reg_written,
                                 // [23:19] reg_index, [55:24] reg_value,
                                 // [87:56] step_count
  output logic        m_tuser    // [0] halted
);

`include "assert_macros.svh"

  logic adv;

  // architectural state
  logic [PC_W-1:0] pc;
  logic [XLEN-1:0] count;
  logic            stopped;

  // execute stage
  logic            s1_valid;
  logic [XLEN-1:0] s1_instr;

  // writeback stage
  logic               s2_valid;
  logic               s2_wr;
  logic [RIDX_W-1:0]  s2_idx;
  logic [XLEN-1:0]    s2_val;
  logic               s2_is_load;
  logic               s2_addr_ok;
  logic [PC_W-1:0]    s2_pc;
  logic               s2_halted;
  status_t            s2_status;
  logic [XLEN-1:0]    s2_count;
  logic [XLEN-1:0]    s2_wval;

  // last register write, covers the read that raced it
  logic              w_valid;
  logic [RIDX_W-1:0] w_idx;
  logic [XLEN-1:0]   w_val;

  // output register
  logic              o_valid;
  logic [PC_W-1:0]   o_pc;
  logic              o_halted;
  status_t           o_status;
  logic              o_wr;
  logic [RIDX_W-1:0] o_idx;
  logic [XLEN-1:0]   o_val;
  logic [XLEN-1:0]   o_count;

  logic [XLEN-1:0]   rf_a;
  logic [XLEN-1:0]   rf_b;
  logic [XLEN-1:0]   ld_data;
  logic [XLEN-1:0]   op_a;
  logic [XLEN-1:0]   op_b;
  logic [RIDX_W-1:0] s1_rs;
  logic [RIDX_W-1:0] s1_rt;
  logic              running;
  exec_t             ex;

  assign adv      = !o_valid || m_tready;
  assign s_tready = adv;

  assign s1_rs   = s1_instr[25:21];
  assign s1_rt   = s1_instr[20:16];
  assign running = s1_valid && !stopped && (s1_instr != '0);

  mre_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .re      (adv),
    .raddr_a (s_tdata[25:21]),
    .raddr_b (s_tdata[20:16]),
    .rdata_a (rf_a),
    .rdata_b (rf_b),
    .we      (adv && s2_valid && s2_wr),
    .waddr   (s2_idx),
    .wdata   (s2_wval)
  );

  mre_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .re    (adv && running && ex.is_load),
    .we    (adv && running && ex.mem_we),
    .addr  (ex.mem_addr),
    .wdata (op_b),
    .rdata (ld_data)
  );

  // bad load still writes zero
  assign s2_wval = s2_is_load ? (s2_addr_ok ? ld_data : '0) : s2_val;

  // operand forwarding: writeback stage first, then last write, then array
  always_comb begin
    if (s2_valid && s2_wr && (s2_idx == s1_rs)) op_a = s2_wval;
    else if (w_valid && (w_idx == s1_rs))       op_a = w_val;
    else                                        op_a = rf_a;
    if (s2_valid && s2_wr && (s2_idx == s1_rt)) op_b = s2_wval;
    else if (w_valid && (w_idx == s1_rt))       op_b = w_val;
    else                                        op_b = rf_b;
  end

  mre_alu u_alu (
    .instr (s1_instr),
    .a     (op_a),
    .b     (op_b),
    .pc    (pc),
    .res   (ex)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      count    <= '0;
      stopped  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      w_valid  <= 1'b0;
      o_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      o_valid  <= s2_valid;
      if (s1_valid && (s1_instr == '0)) stopped <= 1'b1;
      if (running) begin
        pc    <= ex.next_pc;
        count <= count + XLEN'(1);
      end
      if (s2_valid && s2_wr) w_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s_tvalid) s1_instr <= s_tdata;

      s2_wr      <= running && ex.wr_en;
      s2_idx     <= running ? ex.wr_idx : '0;
      s2_val     <= ex.wr_val;
      s2_is_load <= running && ex.is_load;
      s2_addr_ok <= ex.addr_ok;
      s2_pc      <= running ? ex.next_pc : pc;
      s2_halted  <= !running;
      s2_status  <= running ? ex.status : ST_OK;
      s2_count   <= running ? count + XLEN'(1) : count;

      if (s2_valid && s2_wr) begin
        w_idx <= s2_idx;
        w_val <= s2_wval;
      end

      o_pc     <= s2_pc;
      o_halted <= s2_halted;
      o_status <= s2_status;
      o_wr     <= s2_wr;
      o_idx    <= s2_wr ? s2_idx : '0;
      o_val    <= s2_wr ? s2_wval : '0;
      o_count  <= s2_count;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tuser  = o_halted;
  assign m_tdata  = {o_count, o_val, o_idx, o_wr, o_status, o_pc};

  `ASSERT_CLK(a_stop_sticky, stopped |=> stopped, "halt flag cleared without reset")
  `ASSERT_CLK(a_halt_quiet, (m_tvalid && m_tuser) |-> (!o_wr && (o_status == ST_OK)),
              "halted item reports a write or an error")
  `ASSERT_CLK(a_no_r0_write, (s2_valid && s2_wr) |-> (s2_idx != '0),
              "write to r0 reached writeback")

endmodule

// File: rtl/core/mre_regfile.sv
// 32x32 register file, two registered read ports, one write port, reset via valid bits.
module mre_regfile
  import mre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              re,
  input  logic [RIDX_W-1:0] raddr_a,
  input  logic [RIDX_W-1:0] raddr_b,
  output logic [XLEN-1:0]   rdata_a,
  output logic [XLEN-1:0]   rdata_b,
  input  logic              we,
  input  logic [RIDX_W-1:0] waddr,
  input  logic [XLEN-1:0]   wdata
);

  logic [XLEN-1:0] mem [REGS];
  logic [REGS-1:0] vld;
  logic [XLEN-1:0] q_a;
  logic [XLEN-1:0] q_b;
  logic            v_a;
  logic            v_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_a <= mem[raddr_a];
      q_b <= mem[raddr_b];
    end
  end

  // Entries never written read as zero; r0 is never written.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        v_a <= vld[raddr_a];
        v_b <= vld[raddr_b];
      end
    end
  end

  assign rdata_a = v_a ? q_a : '0;
  assign rdata_b = v_b ? q_b : '0;

endmodule

// File: rtl/core/mre_dmem.sv
// Word-addressed data memory with registered read and per-word valid bits.
module mre_dmem
  import mre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               re,
  input  logic               we,
  input  logic [DADDR_W-1:0] addr,
  input  logic [XLEN-1:0]    wdata,
  output logic [XLEN-1:0]    rdata
);

  logic [XLEN-1:0]       mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld;
  logic [XLEN-1:0]       q;
  logic                  q_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[addr] <= 1'b1;
      end
      if (re) begin
        q_vld <= vld[addr];
      end
    end
  end

  assign rdata = q_vld ? q : '0;

endmodule

// File: rtl/core/mre_alu.sv
// Decode and execute of one instruction word with forwarded operands.
module mre_alu
  import mre_pkg::*;
(
  input  logic [XLEN-1:0] instr,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic [PC_W-1:0] pc,
  output exec_t           res
);

  logic [5:0]        op;
  logic [RIDX_W-1:0] rs;
  logic [RIDX_W-1:0] rt;
  logic [RIDX_W-1:0] rd;
  logic [IMM_W-1:0]  imm;
  logic [XLEN-1:0]   imm_x;
  logic [XLEN-1:0]   addr;
  logic              big_shift;
  logic              wr;
  logic [PC_W-1:0]   pc_inc;

  assign op        = instr[31:26];
  assign rs        = instr[25:21];
  assign rt        = instr[20:16];
  assign rd        = instr[15:11];
  assign imm       = instr[15:0];
  assign imm_x     = {{(XLEN-IMM_W){1'b0}}, imm};
  assign addr      = a + imm_x;
  assign big_shift = |imm[IMM_W-1:5];
  assign pc_inc    = pc + PC_W'(1);

  always_comb begin
    wr           = 1'b0;
    res.wr_idx   = rs;
    res.wr_val   = '0;
    res.is_load  = 1'b0;
    res.mem_we   = 1'b0;
    res.addr_ok  = (addr < XLEN'(DATA_WORDS));
    res.mem_addr = addr[DADDR_W-1:0];
    res.status   = ST_OK;
    res.next_pc  = pc_inc;
    case (op)
      OP_ADDI: begin
        wr         = 1'b1;
        res.wr_idx = rt;
        res.wr_val = addr;
      end
      OP_ADD: begin
        wr         = 1'b1;
        res.wr_idx = rd;
        res.wr_val = a + b;
      end
      OP_SLT: begin
        wr         = 1'b1;
        res.wr_idx = rd;
        res.wr_val = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
      end
      OP_BNE: begin
        if (a != b) res.next_pc = imm;
      end
      OP_BEQ: begin
        if (a == b) res.next_pc = imm;
      end
      OP_LW: begin
        wr          = 1'b1;
        res.wr_idx  = rt;
        res.is_load = 1'b1;
        if (!res.addr_ok) res.status = ST_BAD_ADDR;
      end
      OP_SW: begin
        res.mem_we = res.addr_ok;
        if (!res.addr_ok) res.status = ST_BAD_ADDR;
      end
      OP_SRL: begin
        wr         = 1'b1;
        res.wr_val = big_shift ? {XLEN{b[XLEN-1]}}
                               : XLEN'($signed(b) >>> imm[4:0]);
      end
      OP_SLL: begin
        wr         = 1'b1;
        res.wr_val = big_shift ? '0 : (b << imm[4:0]);
      end
      OP_ANDI: begin
        wr         = 1'b1;
        res.wr_val = b & imm_x;
      end
      default: begin
        res.status = ST_BAD_OP;
      end
    endcase
    // writes to r0 vanish
    res.wr_en = wr && (res.wr_idx != '0);
  end

endmodule

// File: test/mre_checker.sv
// Stream monitor, instruction-level predictor and result scoreboard for the executor.
module mre_checker
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [PC_W-1:0]   next_pc;
    logic              halted;
    status_t           status;
    logic              reg_written;
    logic [RIDX_W-1:0] reg_index;
    logic [XLEN-1:0]   reg_value;
    logic [31:0]       step_count;
  } step_result_t;

  // Architectural state as the executor should see it
  logic [PC_W-1:0] arch_pc;
  logic [XLEN-1:0] gpr [REGS];
  logic [XLEN-1:0] dmem [DATA_WORDS];
  logic [31:0]     retired;
  logic            stopped;

  step_result_t results_q[$];
  int           mismatches  = 0;
  int           outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Execute one instruction word against the model state
  task automatic execute_word(input logic [31:0] word, output step_result_t r);
    logic [5:0]        op;
    logic [4:0]        rs, rt, rd;
    logic [15:0]       imm;
    logic [XLEN-1:0]   a, b, addr, wr_val;
    logic [RIDX_W-1:0] wr_idx;
    logic              do_wr;
    r.status = ST_OK;
    do_wr    = 1'b0;
    wr_idx   = '0;
    wr_val   = '0;
    if (word == '0)
      stopped = 1'b1;
    if (!stopped) begin
      op   = word[31:26];
      rs   = word[25:21];
      rt   = word[20:16];
      rd   = word[15:11];
      imm  = word[15:0];
      a    = (rs == '0) ? '0 : gpr[rs];
      b    = (rt == '0) ? '0 : gpr[rt];
      addr = a + {16'b0, imm};
      arch_pc = arch_pc + PC_W'(1);
      case (op)
        OP_ADDI: begin
          do_wr  = 1'b1;
          wr_idx = rt;
          wr_val = a + {16'b0, imm};
        end
        OP_ADD: begin
          do_wr  = 1'b1;
          wr_idx = rd;
          wr_val = a + b;
        end
        OP_SLT: begin
          do_wr  = 1'b1;
          wr_idx = rd;
          wr_val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        OP_BNE: if (a != b) arch_pc = imm;
        OP_BEQ: if (a == b) arch_pc = imm;
        OP_LW: begin
          do_wr  = 1'b1;
          wr_idx = rt;
          if (addr < 32'(DATA_WORDS)) begin
            wr_val = dmem[addr[DADDR_W-1:0]];
          end else begin
            wr_val   = '0;
            r.status = ST_BAD_ADDR;
          end
        end
        OP_SW: begin
          if (addr < 32'(DATA_WORDS))
            dmem[addr[DADDR_W-1:0]] = b;
          else
            r.status = ST_BAD_ADDR;
        end
        OP_SRL: begin
          do_wr  = 1'b1;
          wr_idx = rs;
          // shift of 32 or more leaves only the sign fill
          if (imm >= 16'd32)
            wr_val = {XLEN{b[XLEN-1]}};
          else
            wr_val = $signed(b) >>> imm[4:0];
        end
        OP_SLL: begin
          do_wr  = 1'b1;
          wr_idx = rs;
          if (imm >= 16'd32)
            wr_val = '0;
          else
            wr_val = b << imm[4:0];
        end
        OP_ANDI: begin
          do_wr  = 1'b1;
          wr_idx = rs;
          wr_val = b & {16'b0, imm};
        end
        default: r.status = ST_BAD_OP;
      endcase
      retired = retired + 32'd1;
    end
    // r0 stays zero, its writes are not reported
    if (do_wr && wr_idx != '0) begin
      gpr[wr_idx]   = wr_val;
      r.reg_written = 1'b1;
      r.reg_index   = wr_idx;
      r.reg_value   = wr_val;
    end else begin
      r.reg_written = 1'b0;
      r.reg_index   = '0;
      r.reg_value   = '0;
    end
    r.next_pc    = arch_pc;
    r.halted     = stopped;
    r.step_count = retired;
  endtask

  always @(posedge clk) begin
    step_result_t r;
    step_result_t want;
    if (rst) begin
      arch_pc = '0;
      retired = '0;
      stopped = 1'b0;
      for (int i = 0; i < REGS; i++) gpr[i] = '0;
      for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
      results_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        execute_word(s_tdata, r);
        results_q.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        if (results_q.size() == 0) begin
          report("result item with no instruction outstanding");
        end else begin
          want = results_q.pop_front();
          check_field("next_pc", 32'(m_tdata[15:0]), 32'(want.next_pc));
          check_field("status", 32'(m_tdata[17:16]), 32'(want.status));
          check_field("reg_written", 32'(m_tdata[18]), 32'(want.reg_written));
          check_field("reg_index", 32'(m_tdata[23:19]), 32'(want.reg_index));
          check_field("reg_value", m_tdata[55:24], want.reg_value);
          check_field("step_count", m_tdata[87:56], want.step_count);
          check_field("halted", 32'(m_tuser), 32'(want.halted));
        end
      end
    end
    outstanding = results_q.size();
  end

endmodule

// File: test/tb_top.sv
// Top of the executor testbench: clock, reset, instruction stimulus and verdict.
module tb_top;
  import mre_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int          RANDOM_ITEMS   = 400;
  localparam int          DRAIN_CYCLES   = 8;     // pipeline is 3 deep, plus margin
  localparam logic [5:0]  OP_NONE        = 6'd0;  // op 0: only the all-zero word is legal
  localparam logic [5:0]  OP_FIRST_FREE  = 6'd11; // first unassigned opcode
  localparam logic [5:0]  OP_MAX         = 6'd63;
  localparam logic [31:0] HALT_WORD      = 32'h0000_0000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        m_tuser;

  int fail_count;
  int pending;
  int send_idle_pct = 17;
  int recv_idle_pct = 79;
  int quiet_cycles  = 0;

  mini_risc_instruction_executor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mre_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side backpressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hang detection: any stretch with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] enc_i(input op_t op, input int rs,
                                        input int rt, input logic [15:0] imm);
    return {op, 5'(rs), 5'(rt), imm};
  endfunction

  function automatic logic [31:0] enc_r(input op_t op, input int rs,
                                        input int rt, input int rd);
    return {op, 5'(rs), 5'(rt), 5'(rd), 11'b0};
  endfunction

  // Mostly the low registers so values get reused across instructions
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 4) == 0)
      return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed instructions with useful operands, some illegal opcodes.
  // Never returns the halt word.
  function automatic logic [31:0] random_instruction();
    int          pick;
    int          sel;
    logic [5:0]  op;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm;
    pick = $urandom_range(0, 99);
    rs   = pick_reg();
    rt   = pick_reg();
    rd   = pick_reg();
    imm  = 16'($urandom);
    if (pick < 2)
      return {OP_NONE, 26'($urandom_range(1, 2**26 - 1))};
    if (pick < 8) begin
      op = 6'($urandom_range(int'(OP_FIRST_FREE), int'(OP_MAX)));
      return {op, 26'($urandom)};
    end
    op = 6'($urandom_range(int'(OP_ADDI), int'(OP_ANDI)));
    case (op)
      OP_ADD, OP_SLT: return {op, rs, rt, rd, 11'($urandom)};
      OP_LW, OP_SW: begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          rs  = '0;
          imm = 16'($urandom_range(0, DATA_WORDS - 1));
        end else if (sel < 8) begin
          imm = 16'($urandom_range(0, 15));
        end
      end
      OP_SRL, OP_SLL: if ($urandom_range(0, 9) < 8) imm = 16'($urandom_range(0, 31));
      default: ;
    endcase
    return {op, rs, rt, imm};
  endfunction

  // Present one instruction, with random idle cycles in front, until accepted.
  // s_tready is sampled at the falling edge, where it has settled.
  task automatic send_item(input logic [31:0] word);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: every op, sign and wrap corners, shift saturation, bad addresses
    send_item(enc_i(OP_ADDI, 0, 1, 16'hFFFF));               // r1 = 0x0000ffff
    send_item(enc_i(OP_ADDI, 0, 2, 16'h0001));               // r2 = 1
    send_item(enc_r(OP_ADD, 1, 2, 3));                       // r3 = 0x10000
    send_item(enc_i(OP_SLL, 4, 1, 16'd16));                  // r4 = 0xffff0000
    send_item(enc_i(OP_SRL, 5, 4, 16'd4));                   // arithmetic, negative
    send_item(enc_i(OP_SRL, 6, 4, 16'd40));                  // saturates to all ones
    send_item(enc_i(OP_SRL, 14, 1, 16'hFFFF));               // saturates to zero
    send_item(enc_i(OP_SLL, 7, 1, 16'd32));                  // shifted out entirely
    send_item(enc_i(OP_ANDI, 8, 4, 16'hFFFF));
    send_item(enc_i(OP_ANDI, 15, 6, 16'hFFFF));
    send_item(enc_r(OP_SLT, 4, 1, 9));                       // negative < positive
    send_item(enc_r(OP_SLT, 1, 4, 10));
    send_item(enc_i(OP_ADDI, 6, 13, 16'h0001));              // wraps to zero
    send_item(enc_i(OP_SW, 0, 5, 16'(DATA_WORDS - 1)));      // last valid word
    send_item(enc_i(OP_LW, 0, 11, 16'(DATA_WORDS - 1)));
    send_item(enc_i(OP_LW, 0, 12, 16'(DATA_WORDS)));         // just past the end
    send_item(enc_i(OP_SW, 4, 1, 16'h0000));                 // negative base
    send_item(enc_i(OP_LW, 6, 16, 16'h0001));                // base + imm wraps to 0
    send_item(enc_i(OP_ADDI, 1, 0, 16'h1234));               // r0 write dropped
    send_item(enc_r(OP_ADD, 1, 1, 0));
    send_item(enc_i(OP_BNE, 1, 2, 16'hFFFF));                // taken to top of pc
    send_item(enc_r(OP_ADD, 1, 1, 17));                      // pc wraps to 0
    send_item(enc_i(OP_BEQ, 1, 1, 16'h0005));                // taken
    send_item(enc_i(OP_BEQ, 1, 2, 16'h0100));                // not taken
    send_item(enc_i(OP_BNE, 3, 3, 16'h0200));                // not taken
    send_item({OP_NONE, 26'd1});                             // op 0, nonzero word
    send_item({OP_FIRST_FREE, 26'h3FF_FFFF});
    send_item({OP_MAX, 26'h3FF_FFFF});

    // Random traffic in three backpressure phases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 17;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_item(random_instruction());
    end

    // Halt last, since only reset leaves it; later words must be ignored
    send_item(HALT_WORD);
    repeat (3) send_item(random_instruction());
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
